// ----- design/tes_pkg.sv -----
// shared types and constants of the timed event slot table
`default_nettype none
package tes_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int RESULT_LIMIT   = 16;
  localparam int CNT_W          = $clog2(RESULT_LIMIT);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] SCALE_RESET  = 16'd1000;
  localparam logic [30:0] DEADLINE_MAX = 31'h7FFF_FFFF;
  localparam logic [1:0]  ADDR_SCALE   = 2'd0;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [30:0] now;
    logic [7:0]  ev;
    logic [15:0] iv;
    logic        per;
  } cmd_t;

  typedef struct packed {
    logic [15:0] iv;
    logic [30:0] dl;
    logic [7:0]  ev;
    logic        per;
  } slot_t;

  typedef struct packed {
    logic       fired;
    logic [7:0] ev;
    logic       added;
    logic       full;
    logic       last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } eng_state_t;

endpackage
`default_nettype wire

// ----- design/tes_front.sv -----
// front stage: takes input beats, classifies them and feeds the command queue
`default_nettype none
module tes_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire                 in_action,
  input  wire  [30:0]         in_now_time,
  input  wire  [7:0]          in_event_id,
  input  wire  [15:0]         in_interval_units,
  input  wire                 in_periodic,
  input  wire                 q_full,
  output logic                q_push,
  output tes_pkg::cmd_t       q_cmd
);
  import tes_pkg::*;

  cmd_t cmd_r;
  cmd_t cmd_nxt;
  logic vld_r;
  logic vld_nxt;
  logic accept;

  assign busy   = vld_r & q_full;
  assign accept = start & ~busy;
  assign q_push = vld_r & ~q_full;
  assign q_cmd  = cmd_r;

  always_comb begin
    cmd_nxt = cmd_r;
    vld_nxt = vld_r;
    if (accept) begin
      cmd_nxt.op  = op_t'(in_action);
      cmd_nxt.now = in_now_time;
      cmd_nxt.ev  = in_event_id;
      cmd_nxt.iv  = in_interval_units;
      cmd_nxt.per = in_periodic;
      vld_nxt     = 1'b1;
    end else if (q_push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule
`default_nettype wire

// ----- design/tes_fifo.sv -----
// short command queue between the front stage and the slot engine
`default_nettype none
module tes_fifo (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  tes_pkg::cmd_t       din,
  input  wire                 pop,
  output tes_pkg::cmd_t       dout,
  output logic                full,
  output logic                empty
);
  import tes_pkg::*;

  cmd_t                store_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_r;
  logic [QPTR_W-1:0]   wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r;
  logic [QPTR_W-1:0]   rptr_nxt;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QCNT_W-1:0]   cnt_nxt;
  logic                do_push;
  logic                do_pop;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = store_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

// ----- design/tes_engine.sv -----
// slot engine: scans the slot memory one slot per cycle, adds, fires and re-arms
`default_nettype none
module tes_engine #(
  parameter int SLOT_COUNT = tes_pkg::SLOT_COUNT_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire  [15:0]         scale,
  input  wire                 q_empty,
  input  tes_pkg::cmd_t       q_cmd,
  output logic                q_pop,
  output logic                res_stb,
  output tes_pkg::res_t       res
);
  import tes_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  eng_state_t            state_r;
  eng_state_t            state_nxt;

  slot_t                 mem [SLOT_COUNT];
  slot_t                 rd_r;
  slot_t                 wr_slot;
  logic [IW-1:0]         rd_addr;
  logic                  mem_we;

  logic [SLOT_COUNT-1:0] occ_r;
  logic [SLOT_COUNT-1:0] occ_nxt;

  op_t                   op_r;
  op_t                   op_nxt;
  logic [30:0]           now_r;
  logic [30:0]           now_nxt;
  logic [7:0]            ev_r;
  logic [7:0]            ev_nxt;
  logic [15:0]           iv_r;
  logic [15:0]           iv_nxt;
  logic                  per_r;
  logic                  per_nxt;
  logic [31:0]           span_r;
  logic [31:0]           span_nxt;
  logic [IW-1:0]         idx_r;
  logic [IW-1:0]         idx_nxt;
  logic [IW-1:0]         tgt_r;
  logic [IW-1:0]         tgt_nxt;
  logic                  free_vld_r;
  logic                  free_vld_nxt;
  logic [IW-1:0]         free_idx_r;
  logic [IW-1:0]         free_idx_nxt;
  logic [CNT_W-1:0]      fire_cnt_r;
  logic [CNT_W-1:0]      fire_cnt_nxt;
  logic                  pend_vld_r;
  logic                  pend_vld_nxt;
  logic [7:0]            pend_ev_r;
  logic [7:0]            pend_ev_nxt;
  logic                  stb_r;
  logic                  stb_nxt;
  res_t                  res_r;
  res_t                  res_nxt;

  logic [15:0]           mult_a;
  logic [31:0]           prod;
  logic [32:0]           dl_sum;
  logic [30:0]           dl_sat;
  logic                  last_idx;
  logic                  cur_occ;
  logic                  due;
  logic                  fire;
  logic                  add_hit;
  logic                  cnt_hit;

  assign last_idx = (idx_r == IW'(SLOT_COUNT - 1));
  assign cur_occ  = occ_r[idx_r];
  assign due      = (rd_r.dl <= now_r);
  assign fire     = cur_occ & due;
  assign add_hit  = ~cur_occ | due;
  assign cnt_hit  = (fire_cnt_r == CNT_W'(RESULT_LIMIT - 1));
  assign prod     = {16'b0, mult_a} * {16'b0, scale};
  assign dl_sum   = {2'b0, now_r} + {1'b0, span_r};
  assign dl_sat   = (|dl_sum[32:31]) ? DEADLINE_MAX : dl_sum[30:0];
  assign wr_slot  = '{iv: iv_r, dl: dl_sat, ev: ev_r, per: per_r};
  assign q_pop    = (state_r == ST_IDLE) & ~q_empty;
  assign res_stb  = stb_r;
  assign res      = res_r;

  always_comb begin
    if (state_r == ST_LOAD) begin
      rd_addr = '0;
    end else if (last_idx) begin
      rd_addr = idx_r;
    end else begin
      rd_addr = idx_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (op_r == OP_ADD) begin
          if (add_hit) begin
            state_nxt = ST_WRITE;
          end else if (last_idx) begin
            state_nxt = ST_FINISH;
          end
        end else begin
          if (fire && rd_r.per) begin
            state_nxt = ST_WRITE;
          end else if (last_idx || (fire && cnt_hit)) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_WRITE:  state_nxt = ST_IDLE;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op_nxt       = op_r;
    now_nxt      = now_r;
    ev_nxt       = ev_r;
    iv_nxt       = iv_r;
    per_nxt      = per_r;
    span_nxt     = span_r;
    idx_nxt      = idx_r;
    tgt_nxt      = tgt_r;
    free_vld_nxt = free_vld_r;
    free_idx_nxt = free_idx_r;
    fire_cnt_nxt = fire_cnt_r;
    pend_vld_nxt = pend_vld_r;
    pend_ev_nxt  = pend_ev_r;
    occ_nxt      = occ_r;
    mult_a       = iv_r;
    mem_we       = 1'b0;
    stb_nxt      = 1'b0;
    res_nxt      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          op_nxt  = q_cmd.op;
          now_nxt = q_cmd.now;
          ev_nxt  = q_cmd.ev;
          iv_nxt  = q_cmd.iv;
          per_nxt = q_cmd.per;
        end
      end
      ST_LOAD: begin
        span_nxt     = prod;
        idx_nxt      = '0;
        fire_cnt_nxt = '0;
        pend_vld_nxt = 1'b0;
        free_vld_nxt = 1'b0;
      end
      ST_SCAN: begin
        if (!last_idx) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (op_r == OP_ADD) begin
          if (add_hit) begin
            tgt_nxt = idx_r;
          end
        end else begin
          if ((!cur_occ || fire) && !free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = idx_r;
          end
          if (fire) begin
            occ_nxt[idx_r] = 1'b0;
            fire_cnt_nxt   = fire_cnt_r + 1'b1;
            if (pend_vld_r) begin
              stb_nxt       = 1'b1;
              res_nxt.fired = 1'b1;
              res_nxt.ev    = pend_ev_r;
            end
            pend_vld_nxt = 1'b1;
            pend_ev_nxt  = rd_r.ev;
            if (rd_r.per) begin
              tgt_nxt  = free_vld_r ? free_idx_r : idx_r;
              iv_nxt   = rd_r.iv;
              ev_nxt   = rd_r.ev;
              per_nxt  = 1'b1;
              mult_a   = rd_r.iv;
              span_nxt = prod;
            end
          end
        end
      end
      ST_WRITE: begin
        mem_we         = 1'b1;
        occ_nxt[tgt_r] = (iv_r != '0);
        stb_nxt        = 1'b1;
        res_nxt.last   = 1'b1;
        if (op_r == OP_ADD) begin
          res_nxt.added = 1'b1;
        end else begin
          res_nxt.fired = 1'b1;
          res_nxt.ev    = pend_ev_r;
        end
      end
      ST_FINISH: begin
        stb_nxt      = 1'b1;
        res_nxt.last = 1'b1;
        if (op_r == OP_ADD) begin
          res_nxt.full = 1'b1;
        end else if (pend_vld_r) begin
          res_nxt.fired = 1'b1;
          res_nxt.ev    = pend_ev_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      occ_r      <= '0;
      stb_r      <= 1'b0;
      pend_vld_r <= 1'b0;
      free_vld_r <= 1'b0;
      fire_cnt_r <= '0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      occ_r      <= occ_nxt;
      stb_r      <= stb_nxt;
      pend_vld_r <= pend_vld_nxt;
      free_vld_r <= free_vld_nxt;
      fire_cnt_r <= fire_cnt_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    now_r      <= now_nxt;
    ev_r       <= ev_nxt;
    iv_r       <= iv_nxt;
    per_r      <= per_nxt;
    span_r     <= span_nxt;
    tgt_r      <= tgt_nxt;
    free_idx_r <= free_idx_nxt;
    pend_ev_r  <= pend_ev_nxt;
    res_r      <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tgt_r] <= wr_slot;
    end
    rd_r <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- design/timed_event_slot_table.sv -----
// top level of the timed event slot table
//
// Commands enter on start with in_action (0 = add, 1 = tick), in_now_time,
// in_event_id, in_interval_units and in_periodic; a beat is taken when start
// is high and busy is low. Results leave at most one per cycle on out_strobe with
// out_fired, out_fired_event, out_added, out_table_full and out_last; the
// receiver cannot stall, so every result is shown for exactly one cycle.
// An add gives one result; a tick gives one result per fired slot in slot
// order, or a single empty result when nothing is due, out_last on the final.
// The front stage registers a beat and hands it to a two-entry command queue;
// the engine scans the slot memory one slot per cycle. An item goes through
// pop, load, the slot scan, and write or finish; the scan ends early when an
// add finds a slot, when a periodic slot fires or when a tick reaches the
// result limit. The scale register (ticks per interval unit) is read at APB
// address 0; a write to any address sets it. Reset empties all slots
// through their occupancy flags and sets the scale to 1000.
`default_nettype none
module timed_event_slot_table #(
  parameter int SLOT_COUNT = tes_pkg::SLOT_COUNT_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire         in_action,
  input  wire  [30:0] in_now_time,
  input  wire  [7:0]  in_event_id,
  input  wire  [15:0] in_interval_units,
  input  wire         in_periodic,
  output logic        out_strobe,
  output logic        out_fired,
  output logic [7:0]  out_fired_event,
  output logic        out_added,
  output logic        out_table_full,
  output logic        out_last,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [1:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tes_pkg::*;

  logic [15:0] scale_r;
  logic [15:0] scale_nxt;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  cmd_t        push_cmd;
  cmd_t        pop_cmd;
  logic        res_stb;
  res_t        res;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SCALE) ? {16'b0, scale_r} : '0;

  always_comb begin
    scale_nxt = scale_r;
    if (psel && penable && pwrite && pready) begin
      scale_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else begin
      scale_r <= scale_nxt;
    end
  end

  tes_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_now_time       (in_now_time),
    .in_event_id       (in_event_id),
    .in_interval_units (in_interval_units),
    .in_periodic       (in_periodic),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_cmd             (push_cmd)
  );

  tes_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_cmd),
    .pop   (q_pop),
    .dout  (pop_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  tes_engine #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .scale   (scale_r),
    .q_empty (q_empty),
    .q_cmd   (pop_cmd),
    .q_pop   (q_pop),
    .res_stb (res_stb),
    .res     (res)
  );

  assign out_strobe      = res_stb;
  assign out_fired       = res.fired;
  assign out_fired_event = res.ev;
  assign out_added       = res.added;
  assign out_table_full  = res.full;
  assign out_last        = res.last;

endmodule
`default_nettype wire
